FILE: hw/rtl/rclp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rclp_pkg
// Shared types and constants for the RC ladder plant emulator.
// ----------------------------------------------------------------------------
package rclp_pkg;

  localparam int unsigned R2_W       = 20;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CLK_W      = 64;
  localparam int unsigned TOTAL_W    = 26;  // 65535 * 1000 fits
  localparam int unsigned TICK_W     = 7;   // tick length up to 100 us
  localparam int unsigned SUBMS_W    = 10;  // 0..999 us within a ms
  localparam int unsigned NUM_W      = 64;

  localparam logic [8:0]         RA_OHMS    = 9'd251;
  localparam logic [9:0]         TWO_RA     = 10'd502;
  localparam logic [3:0]         C2_RATIO   = 4'd10;
  localparam logic [TICK_W-1:0]  MS_TICK_US = 7'd100;
  localparam logic [TICK_W-1:0]  US_TICK_US = 7'd10;
  localparam logic [SUBMS_W-1:0] US_PER_MS  = 10'd1000;
  localparam logic [9:0]         MS_SCALE   = 10'd1000;
  localparam logic [R2_W-1:0]    R2_RESET   = 20'd1000;

  // floor(y / 5) = (y * DIV5_MUL) >> DIV5_SH, exact for y below 2^22
  localparam logic [19:0]        DIV5_MUL   = 20'd838861;
  localparam int unsigned        DIV5_SH    = 22;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ACC  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  // micro-op sequence for one tick, then the ADC conversion
  typedef enum logic [3:0] {
    OP_RA_R2   = 4'd0,
    OP_N1_V1   = 4'd1,
    OP_2D_R2   = 4'd2,
    OP_N1_VIN  = 4'd3,
    OP_2RA_D   = 4'd4,
    OP_N1_V2   = 4'd5,
    OP_C2_R2   = 4'd6,
    OP_N2_V2   = 4'd7,
    OP_N2_V1   = 4'd8,
    OP_ADC     = 4'd9,
    OP_ADC_DIV = 4'd10
  } step_e;

endpackage

FILE: hw/rtl/rclp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rclp_if
// Valid/ready channels for drive items and ADC/clock results.
// ----------------------------------------------------------------------------
interface rclp_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic        drive_high;
  logic [15:0] duration;

  modport source (output valid, func, drive_high, duration, input ready);
  modport sink   (input valid, func, drive_high, duration, output ready);
endinterface

interface rclp_out_if #(
  parameter int unsigned ADC_BITS = 10
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_code;
  logic [31:0]         time_us;
  logic [31:0]         time_ms;

  modport source (output valid, adc_code, time_us, time_ms, input ready);
  modport sink   (input valid, adc_code, time_us, time_ms, output ready);
endinterface

FILE: hw/rtl/rc_ladder_plant_emulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_ladder_plant_emulator
// Two-node RC ladder driven by a 0/5 V pin, stepped by semi-implicit Euler.
// ----------------------------------------------------------------------------
// Each item runs T Euler ticks on the shared multiplier and the one-bit-a-cycle
//   divider, then one ADC conversion; T = duration * 10 for ms items,
//   ceil(duration / 10) for us items. Voltages are VW = VOLT_FRAC_BITS + 4 bits.
//   A new item is taken only in idle, once the last result is registered;
//   output stalls delay that. Reset: voltages, clock and ms counter go to zero, r2 to 1000 ohms.
// A config write clears the same voltages and counters and loads r2 from cfg_wdata_i.
module rc_ladder_plant_emulator
  import rclp_pkg::*;
#(
  parameter int unsigned ADC_BITS       = 10,
  parameter int unsigned VOLT_FRAC_BITS = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [R2_W-1:0] cfg_wdata_i,
  rclp_in_if.sink         in_ch_i,
  rclp_out_if.source      out_ch_o
);

  localparam int unsigned VW = VOLT_FRAC_BITS + 4;
  localparam int unsigned MW = (VW > 32) ? VW : 32;
  localparam int unsigned DW = MW;
  localparam int unsigned CW = $clog2(VW);
  localparam logic [VW-1:0] FIVE_V   = VW'(5) << VOLT_FRAC_BITS;
  localparam logic [VW-1:0] ADC_FULL = VW'((1 << ADC_BITS) - 1);

  state_e              state_q, state_d;
  step_e               step_q, step_d;
  logic [CW-1:0]       cnt_q;
  logic [R2_W-1:0]     r2_q;
  logic [VW-1:0]       v1_q, v2_q;
  logic [CLK_W-1:0]    clk_q;
  logic [TIME_W-1:0]   ms_q;
  logic [SUBMS_W-1:0]  subms_q;
  logic                func_q, drive_q;
  logic [TOTAL_W-1:0]  left_q;
  logic [TICK_W-1:0]   d_q;
  logic [NUM_W-1:0]    prod_q, acc_q;
  logic [DW-1:0]       t_q, u_q, w_q, den_q, rem_q;
  logic [VW-1:0]       quo_q;
  logic                out_valid_q;
  logic [ADC_BITS-1:0] adc_q;
  logic [TIME_W-1:0]   tus_q, tms_q;

  logic [MW-1:0]       opa, opb;
  logic [2*MW-1:0]     mul_full;
  logic [TOTAL_W-1:0]  total;
  logic [CLK_W:0]      clk_sum;
  logic                start_tick;
  logic [DW-1:0]       den_new;
  logic [NUM_W-1:0]    num_new;
  logic                div_load;
  logic [DW:0]         trial;
  logic                qbit;
  logic [TOTAL_W-1:0]  left_next;
  logic [SUBMS_W:0]    subms_sum;
  logic [VW-1:0]       vin;
  logic [NUM_W-1:0]    adc_raw;

  function automatic logic [TICK_W-1:0] tick_len(input logic f, input logic [TOTAL_W-1:0] l);
    logic [TICK_W-1:0] r;
    if (!f) begin
      r = MS_TICK_US;
    end else if (l < TOTAL_W'(US_TICK_US)) begin
      r = TICK_W'(l);
    end else begin
      r = US_TICK_US;
    end
    return r;
  endfunction

  assign vin   = drive_q ? FIVE_V : '0;
  assign total = in_ch_i.func ? TOTAL_W'(in_ch_i.duration)
                              : TOTAL_W'(in_ch_i.duration) * TOTAL_W'(MS_SCALE);
  assign clk_sum    = {1'b0, clk_q} + (CLK_W + 1)'(total);
  assign start_tick = (total != '0) && !clk_sum[CLK_W];

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (step_q)
      OP_RA_R2:   begin opa = MW'(r2_q);  opb = MW'(RA_OHMS);          end
      OP_N1_V1:   begin opa = MW'(t_q);   opb = MW'(v1_q);             end
      OP_2D_R2:   begin opa = MW'(r2_q);  opb = MW'({d_q, 1'b0});      end
      OP_N1_VIN:  begin opa = MW'(u_q);   opb = MW'(vin);              end
      OP_2RA_D:   begin opa = MW'(d_q);   opb = MW'(TWO_RA);           end
      OP_N1_V2:   begin opa = MW'(w_q);   opb = MW'(v2_q);             end
      OP_C2_R2:   begin opa = MW'(r2_q);  opb = MW'(C2_RATIO);         end
      OP_N2_V2:   begin opa = MW'(t_q);   opb = MW'(v2_q);             end
      OP_N2_V1:   begin opa = MW'(d_q);   opb = MW'(v1_q);             end
      OP_ADC:     begin opa = MW'(v2_q);  opb = MW'(ADC_FULL);         end
      // divide by 5 V: drop the fraction bits, then reciprocal of 5
      OP_ADC_DIV: begin opa = MW'(acc_q >> VOLT_FRAC_BITS); opb = MW'(DIV5_MUL); end
      default:    begin opa = '0;         opb = '0;                    end
    endcase
  end

  assign mul_full = opa * opb;
  assign adc_raw  = prod_q >> DIV5_SH;

  // denominator and rounded numerator for the two node updates
  always_comb begin
    den_new  = '0;
    div_load = 1'b0;
    unique case (step_q)
      OP_N1_V2: begin
        den_new  = t_q + u_q + w_q;
        div_load = 1'b1;
      end
      OP_N2_V1: begin
        den_new  = t_q + DW'(d_q);
        div_load = 1'b1;
      end
      default: begin
        den_new  = '0;
        div_load = 1'b0;
      end
    endcase
    num_new = div_load ? (acc_q + prod_q + NUM_W'(den_new >> 1)) : prod_q;
  end

  assign trial     = {rem_q, quo_q[VW-1]};
  assign qbit      = trial >= {1'b0, den_q};
  assign left_next = left_q - TOTAL_W'(d_q);
  assign subms_sum = {1'b0, subms_q} + (SUBMS_W + 1)'(d_q);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_ch_i.valid) begin
          state_d = ST_MUL;
          step_d  = start_tick ? OP_RA_R2 : OP_ADC;
        end
      end
      ST_MUL:  state_d = ST_ACC;
      ST_ACC: begin
        if (div_load) begin
          state_d = ST_DIV;
        end else if (step_q == OP_ADC_DIV) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_MUL;
          step_d  = step_e'(step_q + 4'd1);
        end
      end
      ST_DIV: begin
        if (cnt_q == CW'(VW - 1)) begin
          state_d = ST_MUL;
          if (step_q == OP_N1_V2) begin
            step_d = OP_C2_R2;
          end else begin
            step_d = (left_next != '0) ? OP_RA_R2 : OP_ADC;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ch_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= OP_RA_R2;
      cnt_q       <= '0;
      r2_q        <= R2_RESET;
      v1_q        <= '0;
      v2_q        <= '0;
      clk_q       <= '0;
      ms_q        <= '0;
      subms_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if ((state_q == ST_DONE) && (!out_valid_q || out_ch_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        r2_q    <= cfg_wdata_i;
        v1_q    <= '0;
        v2_q    <= '0;
        clk_q   <= '0;
        ms_q    <= '0;
        subms_q <= '0;
      end else begin
        unique case (state_q)
          ST_ACC: cnt_q <= '0;
          ST_DIV: begin
            cnt_q <= cnt_q + CW'(1);
            if (cnt_q == CW'(VW - 1)) begin
              if (step_q == OP_N1_V2) begin
                v1_q <= {quo_q[VW-2:0], qbit};
              end else if (step_q == OP_N2_V1) begin
                v2_q  <= {quo_q[VW-2:0], qbit};
                clk_q <= clk_q + CLK_W'(d_q);
                if (subms_sum >= (SUBMS_W + 1)'(US_PER_MS)) begin
                  subms_q <= SUBMS_W'(subms_sum - (SUBMS_W + 1)'(US_PER_MS));
                  ms_q    <= ms_q + TIME_W'(1);
                end else begin
                  subms_q <= SUBMS_W'(subms_sum);
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_ch_i.valid) begin
          func_q  <= in_ch_i.func;
          drive_q <= in_ch_i.drive_high;
          left_q  <= total;
          d_q     <= tick_len(in_ch_i.func, total);
        end
      end
      ST_MUL: prod_q <= NUM_W'(mul_full);
      ST_ACC: begin
        unique case (step_q)
          OP_RA_R2, OP_C2_R2:  t_q   <= DW'(prod_q);
          OP_2D_R2:            u_q   <= DW'(prod_q);
          OP_2RA_D:            w_q   <= DW'(prod_q);
          OP_N1_V1, OP_N2_V2:  acc_q <= prod_q;
          OP_N1_VIN:           acc_q <= acc_q + prod_q;
          default:             acc_q <= num_new;
        endcase
        if (div_load) begin
          den_q <= den_new;
          rem_q <= DW'(num_new >> VW);
          quo_q <= num_new[VW-1:0];
        end
      end
      ST_DIV: begin
        rem_q <= qbit ? DW'(trial - {1'b0, den_q}) : DW'(trial);
        quo_q <= {quo_q[VW-2:0], qbit};
        if ((cnt_q == CW'(VW - 1)) && (step_q == OP_N2_V1)) begin
          left_q <= left_next;
          d_q    <= tick_len(func_q, left_next);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ch_o.ready) begin
          adc_q <= (adc_raw > NUM_W'(ADC_FULL)) ? ADC_BITS'(ADC_FULL)
                                                : ADC_BITS'(adc_raw);
          tus_q <= clk_q[TIME_W-1:0];
          tms_q <= ms_q;
        end
      end
      default: ;
    endcase
  end

  assign in_ch_i.ready    = (state_q == ST_IDLE);
  assign out_ch_o.valid    = out_valid_q;
  assign out_ch_o.adc_code = adc_q;
  assign out_ch_o.time_us  = tus_q;
  assign out_ch_o.time_ms  = tms_q;

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch_i.ready |-> (state_q == ST_IDLE))
    else $error("input ready outside idle");

  a_v2_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q <= FIVE_V)
    else $error("node 2 above drive level");

  a_subms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    subms_q < US_PER_MS)
    else $error("sub-millisecond count out of range");
`endif

endmodule
